### hdl/ctis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctis_pkg
// Shared types and constants for the cycle timer and interrupt select block.
// ----------------------------------------------------------------------------
package ctis_pkg;

	// Field widths fixed by the item formats.
	localparam int CYCLES_W   = 5;
	localparam int SOURCES    = 5;
	localparam int BYTE_W     = 8;
	localparam int RATE_W     = 2;
	localparam int INDEX_W    = 3;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// Request bit raised by a timer overflow.
	localparam int TIMER_REQ_BIT = 2;

	// Register map, one word per register.
	typedef enum logic [1:0] {
		REG_TIMER_ENABLE = 2'd0,
		REG_RATE_SELECT  = 2'd1,
		REG_RELOAD_VALUE = 2'd2,
		REG_IRQ_MASK     = 2'd3
	} reg_index_t;

	// One instruction report.
	typedef struct packed {
		logic [CYCLES_W-1:0] elapsed_cycles;
		logic                master_enable;
		logic [SOURCES-1:0]  new_requests;
	} in_item_t;

	// One result after the report has been applied.
	typedef struct packed {
		logic [BYTE_W-1:0]  divider_value;
		logic [BYTE_W-1:0]  timer_value;
		logic [SOURCES-1:0] pending_flags;
		logic               interrupt_taken;
		logic [INDEX_W-1:0] interrupt_index;
		logic               master_enable_out;
	} out_item_t;

endpackage

### hdl/ctis_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctis_in_if
// Valid/ready channel that carries instruction reports into the block.
// ----------------------------------------------------------------------------
interface ctis_in_if;
	import ctis_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/ctis_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctis_out_if
// Valid/ready channel that carries results out of the block.
// ----------------------------------------------------------------------------
interface ctis_out_if;
	import ctis_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/cycle_timer_and_interrupt_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_timer_and_interrupt_select_top
// Divider and timer counters advanced by instruction cycle reports, with a
// fixed-priority pick of one pending, enabled interrupt request per report.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake        | Payload
//   ---------+-----------+------------------+-----------------------------------
//   instr    | in        | valid / ready    | elapsed_cycles, master_enable,
//            |           |                  | new_requests
//   result   | out       | valid / ready    | divider_value, timer_value,
//            |           |                  | pending_flags, interrupt_taken,
//            |           |                  | interrupt_index, master_enable_out
//   apb      | in        | psel / penable   | paddr, pwdata, prdata
//
// One report is taken every cycle while results are taken; a result passes
// through the input register, then the result register, from which it
// transfers out. The state update of one report is combinational logic
// between those registers, which is what sets that rate. Reset clears the
// counters, the divider, the timer, the pending flags, the configuration
// registers and the stage valid bits. When the result is not taken, the result register holds,
// the input register fills and holds behind it, and instr.ready then falls.
// ----------------------------------------------------------------------------
module cycle_timer_and_interrupt_select_top #(
	parameter int DIVIDER_PERIOD = 256,
	parameter int TIMER_PERIOD_0 = 1024,
	parameter int TIMER_PERIOD_1 = 16,
	parameter int TIMER_PERIOD_2 = 64,
	parameter int TIMER_PERIOD_3 = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ctis_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ctis_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ctis_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	ctis_in_if.sink                         instr,
	ctis_out_if.source                      result
);
	import ctis_pkg::*;

	// Counter widths cover the largest period plus one report's cycles.
	localparam int TIMER_MAX_01 = (TIMER_PERIOD_0 > TIMER_PERIOD_1) ?
		TIMER_PERIOD_0 : TIMER_PERIOD_1;
	localparam int TIMER_MAX_23 = (TIMER_PERIOD_2 > TIMER_PERIOD_3) ?
		TIMER_PERIOD_2 : TIMER_PERIOD_3;
	localparam int TIMER_MAX = (TIMER_MAX_01 > TIMER_MAX_23) ?
		TIMER_MAX_01 : TIMER_MAX_23;
	localparam int DCW = $clog2(DIVIDER_PERIOD + (1 << CYCLES_W));
	localparam int TCW = $clog2(TIMER_MAX + (1 << CYCLES_W));

	localparam logic [DCW-1:0] DIV_LIMIT = DCW'(DIVIDER_PERIOD);
	localparam logic [TCW-1:0] TIM_LIMIT_0 = TCW'(TIMER_PERIOD_0);
	localparam logic [TCW-1:0] TIM_LIMIT_1 = TCW'(TIMER_PERIOD_1);
	localparam logic [TCW-1:0] TIM_LIMIT_2 = TCW'(TIMER_PERIOD_2);
	localparam logic [TCW-1:0] TIM_LIMIT_3 = TCW'(TIMER_PERIOD_3);

	// Configuration registers.
	logic               timer_enable_q;
	logic [RATE_W-1:0]  rate_select_q;
	logic [BYTE_W-1:0]  reload_value_q;
	logic [SOURCES-1:0] irq_mask_q;

	// Block state.
	logic [DCW-1:0]     div_cnt_q;
	logic [TCW-1:0]     tim_cnt_q;
	logic [BYTE_W-1:0]  divider_q;
	logic [BYTE_W-1:0]  timer_q;
	logic [SOURCES-1:0] flags_q;

	// Input and result stages.
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;

	logic       advance;
	reg_index_t wr_index;
	logic       wr_en;

	// Next-state logic.
	logic [DCW-1:0]     div_sum;
	logic               div_hit;
	logic [TCW-1:0]     tim_sum;
	logic [TCW-1:0]     tim_limit;
	logic               tim_hit;
	logic [SOURCES-1:0] flags_mid;
	logic [SOURCES-1:0] ready_req;
	logic [SOURCES-1:0] flags_next;
	logic [DCW-1:0]     div_cnt_next;
	logic [TCW-1:0]     tim_cnt_next;
	logic [BYTE_W-1:0]  divider_next;
	logic [BYTE_W-1:0]  timer_next;
	logic               taken;
	logic [INDEX_W-1:0] taken_index;

	// The input stage moves on whenever the result register is free or freeing.
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready = !valid_s1 || advance;

	assign result.valid = valid_s2;
	assign result.data  = item_s2;

	// APB port: writes complete in the access cycle, no wait states.
	assign pready   = 1'b1;
	assign wr_index = reg_index_t'(paddr[3:2]);
	assign wr_en    = psel && penable && pwrite;

	always_comb begin
		case (wr_index)
			REG_TIMER_ENABLE: prdata = APB_DATA_W'(timer_enable_q);
			REG_RATE_SELECT:  prdata = APB_DATA_W'(rate_select_q);
			REG_RELOAD_VALUE: prdata = APB_DATA_W'(reload_value_q);
			REG_IRQ_MASK:     prdata = APB_DATA_W'(irq_mask_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_enable_q <= 1'b0;
			rate_select_q  <= '0;
			reload_value_q <= '0;
			irq_mask_q     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TIMER_ENABLE: timer_enable_q <= pwdata[0];
				REG_RATE_SELECT:  rate_select_q  <= pwdata[RATE_W-1:0];
				REG_RELOAD_VALUE: reload_value_q <= pwdata[BYTE_W-1:0];
				REG_IRQ_MASK:     irq_mask_q     <= pwdata[SOURCES-1:0];
				default:          ;
			endcase
		end
	end

	// Divider: bump once the count reaches its period, then clear the count.
	assign div_sum = div_cnt_q + {{(DCW-CYCLES_W){1'b0}}, item_s1.elapsed_cycles};
	assign div_hit = (div_sum >= DIV_LIMIT);

	// Timer period chosen by the rate select register.
	always_comb begin
		case (rate_select_q)
			2'd0:    tim_limit = TIM_LIMIT_0;
			2'd1:    tim_limit = TIM_LIMIT_1;
			2'd2:    tim_limit = TIM_LIMIT_2;
			default: tim_limit = TIM_LIMIT_3;
		endcase
	end

	assign tim_sum = tim_cnt_q + {{(TCW-CYCLES_W){1'b0}}, item_s1.elapsed_cycles};
	assign tim_hit = timer_enable_q && (tim_sum >= tim_limit);

	// Counter updates and timer overflow with reload.
	always_comb begin
		flags_mid    = flags_q | item_s1.new_requests;
		div_cnt_next = div_hit ? '0 : div_sum;
		divider_next = div_hit ? divider_q + 8'd1 : divider_q;
		tim_cnt_next = tim_cnt_q;
		timer_next   = timer_q;
		if (timer_enable_q) begin
			tim_cnt_next = tim_hit ? '0 : tim_sum;
		end
		if (tim_hit) begin
			if (timer_q == 8'hFF) begin
				timer_next               = reload_value_q;
				flags_mid[TIMER_REQ_BIT] = 1'b1;
			end else begin
				timer_next = timer_q + 8'd1;
			end
		end
	end

	// Priority pick: the lowest-numbered pending and enabled request wins.
	assign ready_req = item_s1.master_enable ? (flags_mid & irq_mask_q) : '0;

	always_comb begin
		taken       = 1'b0;
		taken_index = '0;
		flags_next  = flags_mid;
		for (int s = 0; s < SOURCES; s++) begin
			if (ready_req[s] && !taken) begin
				taken         = 1'b1;
				taken_index   = INDEX_W'(s);
				flags_next[s] = 1'b0;
			end
		end
	end

	// State registers, updated as a report leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			tim_cnt_q <= '0;
			divider_q <= '0;
			timer_q   <= '0;
			flags_q   <= '0;
		end else if (advance) begin
			div_cnt_q <= div_cnt_next;
			tim_cnt_q <= tim_cnt_next;
			divider_q <= divider_next;
			timer_q   <= timer_next;
			flags_q   <= flags_next;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (instr.ready) begin
				valid_s1 <= instr.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			item_s1 <= instr.data;
		end
		if (advance) begin
			item_s2.divider_value     <= divider_next;
			item_s2.timer_value       <= timer_next;
			item_s2.pending_flags     <= flags_next;
			item_s2.interrupt_taken   <= taken;
			item_s2.interrupt_index   <= taken_index;
			item_s2.master_enable_out <= item_s1.master_enable && !taken;
		end
	end

	// A dispatched interrupt always drops the master enable.
	a_taken_drops_master: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.interrupt_taken |-> !item_s2.master_enable_out)
		else $error("master enable still set after a dispatch");

	// The dispatched source is no longer pending in the same result.
	a_taken_flag_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.interrupt_taken |->
			!item_s2.pending_flags[item_s2.interrupt_index])
		else $error("dispatched request still pending");

	// The divider count is cleared whenever it reaches its period.
	a_div_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q < DIV_LIMIT)
		else $error("divider count at or above its period");

	// Without a report moving on, the counters and flags stay put.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(div_cnt_q) && $stable(timer_q) && $stable(flags_q))
		else $error("state changed without a report");

endmodule
